### design/aabb_pkg.sv
`timescale 1ns / 1ps

package aabb_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 30;

	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_X = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_Y = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_Z = 2'd2;

	// push axis codes as seen on the result channel
	typedef enum logic [1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	// body half extents, Q14.16 unsigned
	typedef struct packed {
		logic [CFG_DATA_W-1:0] x;
		logic [CFG_DATA_W-1:0] y;
		logic [CFG_DATA_W-1:0] z;
	} half_ext_t;

	// outcome of one obstacle test
	typedef struct packed {
		logic  pushed;
		axis_t axis;
	} push_stat_t;

endpackage

### design/aabb_cfg_regs.sv
`timescale 1ns / 1ps

module aabb_cfg_regs
	import aabb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output half_ext_t              half_ext
);

	half_ext_t half_ext_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ext_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HALF_X: half_ext_q.x <= cfg_data;
				CFG_HALF_Y: half_ext_q.y <= cfg_data;
				CFG_HALF_Z: half_ext_q.z <= cfg_data;
				default: ;
			endcase
		end
	end

	assign half_ext = half_ext_q;

endmodule

### design/aabb_resolve_core.sv
`timescale 1ns / 1ps

module aabb_resolve_core
	import aabb_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          first,
	input  logic signed [31:0]            start_x,
	input  logic signed [31:0]            start_y,
	input  logic signed [31:0]            start_z,
	input  logic                          has_obstacle,
	input  logic signed [31:0]            obstacle_min_x,
	input  logic signed [31:0]            obstacle_min_y,
	input  logic signed [31:0]            obstacle_min_z,
	input  logic signed [31:0]            obstacle_max_x,
	input  logic signed [31:0]            obstacle_max_y,
	input  logic signed [31:0]            obstacle_max_z,
	input  half_ext_t                     half_ext,
	input  logic signed [COORD_WIDTH-1:0] body_x,
	input  logic signed [COORD_WIDTH-1:0] body_y,
	input  logic signed [COORD_WIDTH-1:0] body_z,
	output logic signed [COORD_WIDTH-1:0] next_x,
	output logic signed [COORD_WIDTH-1:0] next_y,
	output logic signed [COORD_WIDTH-1:0] next_z,
	output push_stat_t                    stat
);

	// working width: position range plus room for extents, overlaps and sums
	localparam int EW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 4;

	localparam logic signed [EW-1:0] CMAX = {{(EW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [EW-1:0] CMIN = ~CMAX;
	localparam logic signed [EW-1:0] ZERO = '0;

	function automatic logic signed [COORD_WIDTH-1:0] sat_cw(input logic signed [EW-1:0] v);
		logic signed [COORD_WIDTH-1:0] r;
		if (v > CMAX) begin
			r = CMAX[COORD_WIDTH-1:0];
		end else if (v < CMIN) begin
			r = CMIN[COORD_WIDTH-1:0];
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [EW-1:0] min_e(input logic signed [EW-1:0] a,
		input logic signed [EW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [EW-1:0] max_e(input logic signed [EW-1:0] a,
		input logic signed [EW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic signed [COORD_WIDTH-1:0] cur_x, cur_y, cur_z, sat_y, push_y;
	logic signed [EW-1:0] cx, cy, cz;
	logic signed [EW-1:0] hx, hy2, hz;
	logic signed [EW-1:0] bminx, bminy, bminz, bmaxx, bmaxy, bmaxz;
	logic signed [EW-1:0] aminx, aminy, aminz, amaxx, amaxy, amaxz;
	logic signed [EW-1:0] ox, oy, oz;
	logic signed [EW-1:0] px, py, pz;
	logic                 negx, negy, negz;
	logic                 hit, sel_x, sel_y;

	// start position load with floor clamp on y
	always_comb begin
		sat_y = sat_cw(EW'(start_y));
		cur_x = first ? sat_cw(EW'(start_x)) : body_x;
		cur_y = first ? ((sat_y < 0) ? '0 : sat_y) : body_y;
		cur_z = first ? sat_cw(EW'(start_z)) : body_z;
	end

	// body and obstacle boxes at working width
	always_comb begin
		cx    = EW'(cur_x);
		cy    = EW'(cur_y);
		cz    = EW'(cur_z);
		hx    = signed'({{(EW-CFG_DATA_W){1'b0}}, half_ext.x});
		hy2   = signed'({{(EW-CFG_DATA_W-1){1'b0}}, half_ext.y, 1'b0});
		hz    = signed'({{(EW-CFG_DATA_W){1'b0}}, half_ext.z});
		bminx = EW'(obstacle_min_x);
		bminy = EW'(obstacle_min_y);
		bminz = EW'(obstacle_min_z);
		bmaxx = EW'(obstacle_max_x);
		bmaxy = EW'(obstacle_max_y);
		bmaxz = EW'(obstacle_max_z);
		aminx = cx - hx;
		amaxx = cx + hx;
		aminy = cy;
		amaxy = cy + hy2;
		aminz = cz - hz;
		amaxz = cz + hz;
	end

	// per-axis overlap and push direction from centre sums
	always_comb begin
		ox   = min_e(amaxx, bmaxx) - max_e(aminx, bminx);
		oy   = min_e(amaxy, bmaxy) - max_e(aminy, bminy);
		oz   = min_e(amaxz, bmaxz) - max_e(aminz, bminz);
		negx = (aminx + amaxx) < (bminx + bmaxx);
		negy = (aminy + amaxy) < (bminy + bmaxy);
		negz = (aminz + amaxz) < (bminz + bmaxz);
		px   = cx + (negx ? -ox : ox);
		py   = cy + (negy ? -oy : oy);
		pz   = cz + (negz ? -oz : oz);
	end

	// least overlap axis, ties go to x then y
	always_comb begin
		hit   = has_obstacle && (ox > ZERO) && (oy > ZERO) && (oz > ZERO);
		sel_x = (ox <= oy) && (ox <= oz);
		sel_y = !sel_x && (oy <= oz);
		push_y = sat_cw(py);
		next_x = cur_x;
		next_y = cur_y;
		next_z = cur_z;
		stat.pushed = hit;
		stat.axis   = AXIS_NONE;
		if (hit) begin
			if (sel_x) begin
				next_x    = sat_cw(px);
				stat.axis = AXIS_X;
			end else if (sel_y) begin
				next_y    = (push_y < 0) ? '0 : push_y;
				stat.axis = AXIS_Y;
			end else begin
				next_z    = sat_cw(pz);
				stat.axis = AXIS_Z;
			end
		end
	end

endmodule

### design/aabb_push_out_resolver_top.sv
`timescale 1ns / 1ps

// Box push-out resolver: moves a body box out of a stream of obstacle boxes.
// Item channel (item_valid / item_stall) carries one obstacle per transfer;
// first loads the start position, last_obstacle marks the end of a run.
// Result channel (res_valid / res_stall) returns one position per item, with
// pushed, push_axis and done_res echoing last_obstacle.
// Configuration channel (cfg_valid / cfg_ready) writes the three half extents
// at index 0, 1, 2; write only while no item is in flight.
// An item goes through the input register, then the result register; a
// stall on the result side can hold it in either register.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single position update loop through the resolve logic.
// Reset clears the position to the origin, the half extents to zero and
// empties both registers. When the receiver stalls, the result register
// holds and one more item can still be taken into the input register;
// after that item_stall rises until the result is taken.
module aabb_push_out_resolver_top
	import aabb_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   first,
	input  logic signed [31:0]     start_x,
	input  logic signed [31:0]     start_y,
	input  logic signed [31:0]     start_z,
	input  logic                   has_obstacle,
	input  logic signed [31:0]     obstacle_min_x,
	input  logic signed [31:0]     obstacle_min_y,
	input  logic signed [31:0]     obstacle_min_z,
	input  logic signed [31:0]     obstacle_max_x,
	input  logic signed [31:0]     obstacle_max_y,
	input  logic signed [31:0]     obstacle_max_z,
	input  logic                   last_obstacle,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic signed [31:0]     resolved_x,
	output logic [30:0]            resolved_y,
	output logic signed [31:0]     resolved_z,
	output logic                   pushed,
	output logic [1:0]             push_axis,
	output logic                   done_res
);

	localparam int EW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;

	localparam logic signed [EW-1:0] OMAX = {{(EW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [EW-1:0] OMIN = ~OMAX;

	function automatic logic signed [31:0] clamp_out(input logic signed [EW-1:0] v);
		logic signed [31:0] r;
		if (v > OMAX) begin
			r = OMAX[31:0];
		end else if (v < OMIN) begin
			r = OMIN[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	half_ext_t half_ext;

	logic                 vld_s1;
	logic                 first_s1, has_obs_s1, last_s1;
	logic signed [31:0]   start_x_s1, start_y_s1, start_z_s1;
	logic signed [31:0]   min_x_s1, min_y_s1, min_z_s1;
	logic signed [31:0]   max_x_s1, max_y_s1, max_z_s1;

	logic signed [COORD_WIDTH-1:0] body_x_q, body_y_q, body_z_q;
	logic signed [COORD_WIDTH-1:0] next_x, next_y, next_z;
	logic signed [31:0]            out_y;
	push_stat_t                    stat;

	logic                 res_valid_q;
	logic signed [31:0]   res_x_q, res_z_q;
	logic [30:0]          res_y_q;
	push_stat_t           stat_q;
	logic                 done_q;

	logic out_free, item_xfer, adv;

	aabb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.half_ext  (half_ext)
	);

	// handshake: result register free or draining this cycle
	assign out_free   = !res_valid_q || !res_stall;
	assign adv        = vld_s1 && out_free;
	assign item_stall = vld_s1 && !out_free;
	assign item_xfer  = item_valid && !item_stall;

	// input register valid, loads whenever the input side is open
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			first_s1   <= first;
			has_obs_s1 <= has_obstacle;
			last_s1    <= last_obstacle;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			start_z_s1 <= start_z;
			min_x_s1   <= obstacle_min_x;
			min_y_s1   <= obstacle_min_y;
			min_z_s1   <= obstacle_min_z;
			max_x_s1   <= obstacle_max_x;
			max_y_s1   <= obstacle_max_y;
			max_z_s1   <= obstacle_max_z;
		end
	end

	aabb_resolve_core #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_core (
		.first          (first_s1),
		.start_x        (start_x_s1),
		.start_y        (start_y_s1),
		.start_z        (start_z_s1),
		.has_obstacle   (has_obs_s1),
		.obstacle_min_x (min_x_s1),
		.obstacle_min_y (min_y_s1),
		.obstacle_min_z (min_z_s1),
		.obstacle_max_x (max_x_s1),
		.obstacle_max_y (max_y_s1),
		.obstacle_max_z (max_z_s1),
		.half_ext       (half_ext),
		.body_x         (body_x_q),
		.body_y         (body_y_q),
		.body_z         (body_z_q),
		.next_x         (next_x),
		.next_y         (next_y),
		.next_z         (next_z),
		.stat           (stat)
	);

	// body position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_x_q <= '0;
			body_y_q <= '0;
			body_z_q <= '0;
		end else if (adv) begin
			body_x_q <= next_x;
			body_y_q <= next_y;
			body_z_q <= next_z;
		end
	end

	// y is never negative, so only the upper clamp matters
	assign out_y = clamp_out(EW'(next_y));

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= vld_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_x_q <= clamp_out(EW'(next_x));
			res_y_q <= out_y[30:0];
			res_z_q <= clamp_out(EW'(next_z));
			stat_q  <= stat;
			done_q  <= last_s1;
		end
	end

	assign res_valid  = res_valid_q;
	assign resolved_x = res_x_q;
	assign resolved_y = res_y_q;
	assign resolved_z = res_z_q;
	assign pushed     = stat_q.pushed;
	assign push_axis  = stat_q.axis;
	assign done_res   = done_q;

`ifndef SYNTHESIS
	// pushed and a nonzero axis always come together
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (pushed == (stat_q.axis != AXIS_NONE)))
		else $error("pushed flag and push axis disagree");

	// the floor clamp keeps the stored position on or above zero
	assert property (@(posedge clk) disable iff (!arst_n)
		!body_y_q[COORD_WIDTH-1])
		else $error("body y below floor");

	// an item that leaves the input register shows up as a result
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid)
		else $error("advanced item produced no result");

	// a stalled result keeps the input side from overwriting a held item
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && res_valid && res_stall) |-> item_stall)
		else $error("input register overrun while result stalled");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import aabb_pkg::*;

	localparam int     H           = 65536;
	localparam int     CMAX        = 2147483647;
	localparam int     CMIN        = -2147483647 - 1;
	localparam int     COORD_W     = 32;
	localparam longint POS_MAX     = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint POS_MIN     = -POS_MAX - 1;
	localparam int     STALL_LIMIT = 2000;

	// one obstacle item as it goes over the item channel
	typedef struct {
		logic first;
		int   sx, sy, sz;
		logic has;
		int   lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
		logic last;
	} obstacle_item_t;

	// position result as it comes back
	typedef struct {
		int          x;
		logic [30:0] y;
		int          z;
		logic        pushed;
		axis_t       axis;
		logic        done;
	} placed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_HALF_X;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               first = 1'b0;
	logic signed [31:0] start_x = '0;
	logic signed [31:0] start_y = '0;
	logic signed [31:0] start_z = '0;
	logic               has_obstacle = 1'b0;
	logic signed [31:0] obstacle_min_x = '0;
	logic signed [31:0] obstacle_min_y = '0;
	logic signed [31:0] obstacle_min_z = '0;
	logic signed [31:0] obstacle_max_x = '0;
	logic signed [31:0] obstacle_max_y = '0;
	logic signed [31:0] obstacle_max_z = '0;
	logic               last_obstacle = 1'b0;

	logic               res_valid;
	logic               res_stall = 1'b0;
	logic signed [31:0] resolved_x;
	logic [30:0]        resolved_y;
	logic signed [31:0] resolved_z;
	logic               pushed;
	logic [1:0]         push_axis;
	logic               done_res;

	// predictor state: body position and half extents
	longint pos_x = 0, pos_y = 0, pos_z = 0;
	longint ext_x = 0, ext_y = 0, ext_z = 0;

	obstacle_item_t obstacle_queue[$];
	placed_t        predicted_pos[$];
	obstacle_item_t bus_item;

	bit quiet_send = 1'b0;
	bit quiet_recv = 1'b0;
	int send_gap = 0;
	int recv_hold = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	aabb_push_out_resolver_top dut (.*);

	always #1 clk = ~clk;

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint lmin(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	// moves the body out of one obstacle and returns the new position
	function automatic placed_t resolve_item(obstacle_item_t it);
		longint  ax0, ax1, ay0, ay1, az0, az1;
		longint  ov_x, ov_y, ov_z;
		placed_t r;
		r.pushed = 1'b0;
		r.axis   = AXIS_NONE;
		if (it.first) begin
			pos_x = clip(longint'(it.sx), POS_MIN, POS_MAX);
			pos_y = lmax(clip(longint'(it.sy), POS_MIN, POS_MAX), 0);
			pos_z = clip(longint'(it.sz), POS_MIN, POS_MAX);
		end
		if (it.has) begin
			ax0 = pos_x - ext_x;
			ax1 = pos_x + ext_x;
			ay0 = pos_y;
			ay1 = pos_y + 2 * ext_y;
			az0 = pos_z - ext_z;
			az1 = pos_z + ext_z;
			ov_x = lmin(ax1, longint'(it.hi_x)) - lmax(ax0, longint'(it.lo_x));
			ov_y = lmin(ay1, longint'(it.hi_y)) - lmax(ay0, longint'(it.lo_y));
			ov_z = lmin(az1, longint'(it.hi_z)) - lmax(az0, longint'(it.lo_z));
			if (ov_x > 0 && ov_y > 0 && ov_z > 0) begin
				r.pushed = 1'b1;
				// least overlap wins, x before y before z; away from obstacle centre
				if (ov_x <= ov_y && ov_x <= ov_z) begin
					r.axis = AXIS_X;
					if (ax0 + ax1 < longint'(it.lo_x) + longint'(it.hi_x))
						ov_x = -ov_x;
					pos_x = clip(pos_x + ov_x, POS_MIN, POS_MAX);
				end else if (ov_y <= ov_z) begin
					r.axis = AXIS_Y;
					if (ay0 + ay1 < longint'(it.lo_y) + longint'(it.hi_y))
						ov_y = -ov_y;
					pos_y = clip(pos_y + ov_y, POS_MIN, POS_MAX);
				end else begin
					r.axis = AXIS_Z;
					if (az0 + az1 < longint'(it.lo_z) + longint'(it.hi_z))
						ov_z = -ov_z;
					pos_z = clip(pos_z + ov_z, POS_MIN, POS_MAX);
				end
				pos_y = lmax(pos_y, 0);
			end
		end
		r.x    = int'(clip(pos_x, longint'(CMIN), longint'(CMAX)));
		r.y    = 31'(clip(pos_y, 0, longint'(CMAX)));
		r.z    = int'(clip(pos_z, longint'(CMIN), longint'(CMAX)));
		r.done = it.last;
		return r;
	endfunction

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : int'($urandom_range(0, 17));
	endfunction

	function automatic int sat32(longint v);
		return int'(clip(v, longint'(CMIN), longint'(CMAX)));
	endfunction

	function automatic longint jitter(int reach);
		return longint'($urandom_range(0, 2 * reach)) - longint'(reach);
	endfunction

	// item channel driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap   <= 0;
		end else begin
			if (item_valid && !item_stall)
				predicted_pos.push_back(resolve_item(bus_item));
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					item_valid <= 1'b0;
					send_gap   <= send_gap - 1;
				end else if (obstacle_queue.size() != 0) begin
					bus_item = obstacle_queue.pop_front();
					item_valid     <= 1'b1;
					first          <= bus_item.first;
					start_x        <= bus_item.sx;
					start_y        <= bus_item.sy;
					start_z        <= bus_item.sz;
					has_obstacle   <= bus_item.has;
					obstacle_min_x <= bus_item.lo_x;
					obstacle_min_y <= bus_item.lo_y;
					obstacle_min_z <= bus_item.lo_z;
					obstacle_max_x <= bus_item.hi_x;
					obstacle_max_y <= bus_item.hi_y;
					obstacle_max_z <= bus_item.hi_z;
					last_obstacle  <= bus_item.last;
					send_gap       <= draw_wait(quiet_send);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result channel monitor and checker
	always @(posedge clk) begin
		placed_t want;
		int      w;
		if (!arst_n) begin
			res_stall <= 1'b0;
			recv_hold <= 0;
		end else if (res_valid && !res_stall) begin
			if (predicted_pos.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result x=%0d y=%0d z=%0d pushed=%0b axis=%0d done=%0b",
						resolved_x, resolved_y, resolved_z, pushed, push_axis, done_res);
				mismatches++;
			end else begin
				want = predicted_pos.pop_front();
				if (resolved_x !== want.x || resolved_y !== want.y || resolved_z !== want.z ||
						pushed !== want.pushed || push_axis !== want.axis ||
						done_res !== want.done) begin
					if (mismatches < 10) begin
						$display("mismatch: expected x=%0d y=%0d z=%0d pushed=%0b axis=%0d done=%0b",
							want.x, want.y, want.z, want.pushed, want.axis, want.done);
						$display("          actual   x=%0d y=%0d z=%0d pushed=%0b axis=%0d done=%0b",
							resolved_x, resolved_y, resolved_z, pushed, push_axis, done_res);
					end
					mismatches++;
				end
			end
			w = draw_wait(quiet_recv);
			recv_hold <= w;
			res_stall <= (w != 0);
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			res_stall <= (recv_hold > 1);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_HALF_X: ext_x = longint'(val);
			CFG_HALF_Y: ext_y = longint'(val);
			CFG_HALF_Z: ext_z = longint'(val);
			default: ;
		endcase
	endtask

	task automatic set_extents(input logic [CFG_DATA_W-1:0] hx, hy, hz);
		write_reg(CFG_HALF_X, hx);
		write_reg(CFG_HALF_Y, hy);
		write_reg(CFG_HALF_Z, hz);
	endtask

	task automatic queue_item(input bit f, input int sx, sy, sz, input bit h,
			input int lx, ly, lz, hx, hy, hz, input bit l);
		obstacle_item_t it;
		it.first = f;
		it.sx    = sx;
		it.sy    = sy;
		it.sz    = sz;
		it.has   = h;
		it.lo_x  = lx;
		it.lo_y  = ly;
		it.lo_z  = lz;
		it.hi_x  = hx;
		it.hi_y  = hy;
		it.hi_z  = hz;
		it.last  = l;
		obstacle_queue.push_back(it);
	endtask

	// random interval around a centre, now and then inverted
	task automatic make_span(input longint centre, input int reach, output int lo, hi);
		longint hw;
		hw = longint'($urandom_range(0, reach));
		lo = sat32(centre - hw);
		hi = sat32(centre + hw);
		if ($urandom_range(0, 15) == 0) begin
			lo = sat32(centre + hw);
			hi = sat32(centre - hw);
		end
	endtask

	task automatic queue_noise();
		queue_item($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom_range(0, 1),
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
	endtask

	// one resolution: a start load, then obstacles near the start, last one marked
	task automatic queue_run(input int reach, output int count);
		int             n_obs, sx, sy, sz;
		obstacle_item_t it;
		n_obs = $urandom_range(1, 8);
		case ($urandom_range(0, 3))
			0: begin
				sx = $urandom;
				sy = $urandom;
				sz = $urandom;
			end
			1: begin
				sx = sat32(($urandom_range(0, 1) ? longint'(CMAX) : longint'(CMIN)) + jitter(reach));
				sy = sat32(longint'(CMAX) - longint'($urandom_range(0, reach)));
				sz = sat32(($urandom_range(0, 1) ? longint'(CMAX) : longint'(CMIN)) + jitter(reach));
			end
			default: begin
				sx = sat32(jitter(reach));
				sy = sat32(jitter(reach));
				sz = sat32(jitter(reach));
			end
		endcase
		for (int i = 0; i < n_obs; i++) begin
			it.first = (i == 0);
			it.sx    = (i == 0) ? sx : int'($urandom);
			it.sy    = (i == 0) ? sy : int'($urandom);
			it.sz    = (i == 0) ? sz : int'($urandom);
			it.has   = ($urandom_range(0, 9) != 0);
			make_span(longint'(sx) + jitter(reach), reach, it.lo_x, it.hi_x);
			make_span(longint'(sy) + ext_y + jitter(reach), reach, it.lo_y, it.hi_y);
			make_span(longint'(sz) + jitter(reach), reach, it.lo_z, it.hi_z);
			it.last  = (i == n_obs - 1);
			obstacle_queue.push_back(it);
		end
		count = n_obs;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_extent();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return CFG_DATA_W'($urandom);
			3: return CFG_DATA_W'($urandom_range(0, 8 * H));
			default: return CFG_DATA_W'($urandom_range(1, 1024));
		endcase
	endfunction

	// wait until every item went through and the block is quiet again
	task automatic drain();
		while (obstacle_queue.size() != 0 || item_valid || predicted_pos.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// stimulus sequence
	initial begin
		int     reach, n, got;
		longint widest;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases, unit half extents
		set_extents(H, H, H);
		// before any start load, push from the reset position
		queue_item(0, 5 * H, 5 * H, 5 * H, 1, H / 2, 0, -H, 3 * H, 2 * H, H, 0);
		// start below the floor, no obstacle
		queue_item(1, 0, -5 * H, 0, 0, -1, -1, -1, -1, -1, -1, 0);
		queue_item(0, 0, 0, 0, 1, -3 * H, 0, -H, -H / 2, 2 * H, H, 0);
		// equal centres on a three-way tie
		queue_item(1, 0, 0, 0, 1, -H, 0, -H, H, 2 * H, H, 0);
		// y push down, clamped at the floor
		queue_item(1, 0, 0, 0, 1, -2 * H, 3 * H / 2, -2 * H, 2 * H, 5 * H, 2 * H, 0);
		// y push up
		queue_item(1, 0, 3 * H, 0, 1, -2 * H, 0, -2 * H, 2 * H, 7 * H / 2, 2 * H, 0);
		// z push down
		queue_item(1, 0, 0, 0, 1, -2 * H, -2 * H, H / 2, 2 * H, 4 * H, 2 * H, 0);
		// y and z tie
		queue_item(1, 0, 0, 0, 1, -3 * H, H, 0, 3 * H, 4 * H, 3 * H, 0);
		// x and y tie
		queue_item(1, 0, 0, 0, 1, 0, H, -3 * H, 3 * H, 4 * H, 3 * H, 0);
		// inverted box
		queue_item(1, 0, 0, 0, 1, 2 * H, 0, -H, -2 * H, 2 * H, H, 0);
		// touching faces, zero overlap
		queue_item(1, 0, 0, 0, 1, H, 0, -H, 3 * H, 2 * H, H, 0);
		queue_item(1, 0, 0, 0, 1, -H, 2 * H, -H, H, 4 * H, H, 0);
		// saturation at both ends of x and the top of z
		queue_item(1, CMAX, 0, CMAX, 1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
		queue_item(1, CMIN, 0, CMIN, 1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
		queue_item(1, 0, 0, CMAX, 1, -4 * H, CMIN, CMIN, 4 * H, CMAX, CMAX, 0);
		// y right at the top of the range
		queue_item(1, 0, CMAX - H / 2, 0, 1, -4 * H, CMIN, -4 * H, 4 * H, CMAX, 4 * H, 1);
		// all ones and all zeros
		queue_item(1, -1, -1, -1, 1, -1, -1, -1, -1, -1, -1, 1);
		queue_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_item(1, 0, CMIN, 0, 1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1);
		queue_item(0, CMAX, CMAX, CMAX, 1, -H, 0, -H, H, H, H, 1);
		drain();

		// random runs under changing extents and idle patterns
		for (int p = 0; p < 8; p++) begin
			if (p == 0)
				set_extents('1, '1, '1);
			else if (p == 1)
				set_extents('0, '0, '0);
			else
				set_extents(pick_extent(), pick_extent(), pick_extent());
			quiet_send = p[0];
			quiet_recv = p[1];
			widest = lmax(ext_x, lmax(ext_y, ext_z));
			reach = int'(clip(3 * widest + H, 1, 1 << 29));
			n = 0;
			while (n < 210) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_noise();
					n++;
				end else begin
					queue_run(reach, got);
					n += got;
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_pos.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
